// File: rtl/core/tea_interlace_chain_cipher_macros.svh
// ----------------------------------------------------------------------------
// tea_interlace_chain_cipher_macros.svh
// Assertion macros used by the cipher checker
// ----------------------------------------------------------------------------
`ifndef TEA_INTERLACE_CHAIN_CIPHER_MACROS_SVH
`define TEA_INTERLACE_CHAIN_CIPHER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define TICC_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define TICC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/core/ticc_pkg.sv
// ----------------------------------------------------------------------------
// ticc_pkg
// Constants, register indexes and shared types of the TEA chaining cipher
// ----------------------------------------------------------------------------
package ticc_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned RoundLogW = 3;
	// round counter holds up to 2^8 - 1
	localparam int unsigned RoundCntW = 8;

	localparam logic [WordW-1:0] TeaDelta = 32'h9E37_79B9;
	localparam logic [WordW-1:0] TailMask = 32'hFFFF_FF00;
	localparam int unsigned ShiftLeft = 4;
	localparam int unsigned ShiftRight = 5;

	localparam logic [RoundLogW-1:0] RoundLogReset = 3'd4;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] RegKeyZero = 3'd0;
	localparam logic [CfgIdxW-1:0] RegKeyOne = 3'd1;
	localparam logic [CfgIdxW-1:0] RegKeyTwo = 3'd2;
	localparam logic [CfgIdxW-1:0] RegKeyThree = 3'd3;
	localparam logic [CfgIdxW-1:0] RegRoundLog = 3'd4;

	// operation codes
	localparam logic OpEncrypt = 1'b0;
	localparam logic OpDecrypt = 1'b1;

	// control of the shared half-round unit
	typedef struct packed {
		logic subtract;   // decrypt direction
		logic hi_half;    // keys two/three, updates second word
	} ticc_ctl_t;

endpackage

// File: rtl/core/ticc_round.sv
// ----------------------------------------------------------------------------
// ticc_round
// Shared TEA half-round: acc +/- mix(v, sum, ka, kb)
// ----------------------------------------------------------------------------
module ticc_round import ticc_pkg::*; (
	input  ticc_ctl_t        ctl,
	input  logic [WordW-1:0] v,
	input  logic [WordW-1:0] acc,
	input  logic [WordW-1:0] sum,
	input  logic [WordW-1:0] key_a_lo,
	input  logic [WordW-1:0] key_b_lo,
	input  logic [WordW-1:0] key_a_hi,
	input  logic [WordW-1:0] key_b_hi,
	output logic [WordW-1:0] acc_next
);

	logic [WordW-1:0] key_a;
	logic [WordW-1:0] key_b;
	logic [WordW-1:0] mix;

	// key pair for this half
	assign key_a = ctl.hi_half ? key_a_hi : key_a_lo;
	assign key_b = ctl.hi_half ? key_b_hi : key_b_lo;

	// mixing function, all adds wrap
	assign mix = ((v << ShiftLeft) + key_a) ^ (v + sum) ^ ((v >> ShiftRight) + key_b);

	assign acc_next = ctl.subtract ? (acc - mix) : (acc + mix);

endmodule

// File: rtl/core/tea_interlace_chain_cipher.sv
// ----------------------------------------------------------------------------
// tea_interlace_chain_cipher
// TEA block cipher with interlaced chaining, one 64-bit block per beat
// ----------------------------------------------------------------------------
// Each block runs 2^round_log2 TEA rounds (16 at the default), each as two
// halves in one shared half-round unit, followed by a final step that folds
// in the chaining words and registers the result. The sequencer is back in
// idle on that same edge, so the next block can be accepted once the result
// is registered. The input is stalled while a block is in flight; a
// finished result waits in the output register and the next block may be
// taken meanwhile, but a block that finishes while that register is still
// held stays in its last cycle, with the input stalled, until the beat
// leaves. Key and round_log2 writes belong between blocks, while none is in
// flight.
module tea_interlace_chain_cipher import ticc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [WordW-1:0]   cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic               first_block,
	input  logic               last_block,
	input  logic [WordW-1:0]   first_word,
	input  logic [WordW-1:0]   second_word,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [WordW-1:0]   result_first_word,
	output logic [WordW-1:0]   result_second_word,
	output logic               result_last,
	output logic               tail_ok
);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		FIN
	} state_t;

	state_t state_q;

	logic [WordW-1:0]     key_zero_q;
	logic [WordW-1:0]     key_one_q;
	logic [WordW-1:0]     key_two_q;
	logic [WordW-1:0]     key_three_q;
	logic [RoundLogW-1:0] round_log_q;

	logic [2*WordW-1:0]   chain_text_q;
	logic [2*WordW-1:0]   chain_core_q;

	logic [WordW-1:0]     y_q;
	logic [WordW-1:0]     z_q;
	logic [WordW-1:0]     sum_q;
	logic [RoundCntW-1:0] cnt_q;
	logic                 phase_q;
	logic                 dec_q;
	logic                 last_q;
	logic [2*WordW-1:0]   blk_q;
	logic                 out_valid_q;

	logic                 in_take;
	logic                 out_free;
	logic [2*WordW-1:0]   blk_in;
	logic [2*WordW-1:0]   ptext;
	logic [2*WordW-1:0]   pcore;
	logic [2*WordW-1:0]   core_in;
	logic [2*WordW-1:0]   core_out;
	logic [2*WordW-1:0]   res;
	logic                 res_tail;
	logic [RoundCntW-1:0] round_total;
	ticc_ctl_t            ctl;
	logic [WordW-1:0]     unit_v;
	logic [WordW-1:0]     unit_acc;
	logic [WordW-1:0]     unit_out;
	logic [WordW-1:0]     sum_next;

	// handshake
	assign in_stall = (state_q != IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// chaining words seen by a new block, cleared on a first block
	assign blk_in  = {second_word, first_word};
	assign ptext   = first_block ? '0 : chain_text_q;
	assign pcore   = first_block ? '0 : chain_core_q;
	assign core_in = blk_in ^ ((operation == OpDecrypt) ? pcore : ptext);

	assign round_total = RoundCntW'(1) << round_log_q;

	// shared unit: low half updates y from z, high half updates z from y
	assign ctl.subtract = dec_q;
	assign ctl.hi_half  = dec_q ^ phase_q;
	assign unit_v   = ctl.hi_half ? y_q : z_q;
	assign unit_acc = ctl.hi_half ? z_q : y_q;
	assign sum_next = dec_q ? (sum_q - TeaDelta) : (sum_q + TeaDelta);

	ticc_round u_round (
		.ctl      (ctl),
		.v        (unit_v),
		.acc      (unit_acc),
		.sum      (sum_q),
		.key_a_lo (key_zero_q),
		.key_b_lo (key_one_q),
		.key_a_hi (key_two_q),
		.key_b_hi (key_three_q),
		.acc_next (unit_out)
	);

	// chaining output of the finished block
	assign core_out = {z_q, y_q};
	assign res = core_out ^ (dec_q ? chain_text_q : chain_core_q);
	assign res_tail = dec_q && last_q && (res[2*WordW-1:WordW] == '0)
		&& ((res[WordW-1:0] & TailMask) == '0);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_zero_q  <= '0;
			key_one_q   <= '0;
			key_two_q   <= '0;
			key_three_q <= '0;
			round_log_q <= RoundLogReset;
		end else if (cfg_we) begin
			case (cfg_index)
				RegKeyZero:  key_zero_q  <= cfg_data;
				RegKeyOne:   key_one_q   <= cfg_data;
				RegKeyTwo:   key_two_q   <= cfg_data;
				RegKeyThree: key_three_q <= cfg_data;
				RegRoundLog: round_log_q <= cfg_data[RoundLogW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, chaining state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= IDLE;
			out_valid_q        <= 1'b0;
			chain_text_q       <= '0;
			chain_core_q       <= '0;
			phase_q            <= 1'b0;
			cnt_q              <= '0;
			y_q                <= '0;
			z_q                <= '0;
			sum_q              <= '0;
			dec_q              <= 1'b0;
			last_q             <= 1'b0;
			blk_q              <= '0;
			result_first_word  <= '0;
			result_second_word <= '0;
			result_last        <= 1'b0;
			tail_ok            <= 1'b0;
		end else begin
			// result beat: loaded by a finished block, emptied when taken
			if ((state_q == FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_take) begin
						chain_text_q <= ptext;
						chain_core_q <= pcore;
						blk_q   <= blk_in;
						dec_q   <= operation;
						last_q  <= last_block;
						y_q     <= core_in[WordW-1:0];
						z_q     <= core_in[2*WordW-1:WordW];
						sum_q   <= (operation == OpDecrypt) ? WordW'(TeaDelta << round_log_q)
							: TeaDelta;
						cnt_q   <= round_total - RoundCntW'(1);
						phase_q <= 1'b0;
						state_q <= RUN;
					end
				end
				RUN: begin
					if (ctl.hi_half) begin
						z_q <= unit_out;
					end else begin
						y_q <= unit_out;
					end
					phase_q <= !phase_q;
					// end of a full round
					if (phase_q) begin
						sum_q <= sum_next;
						cnt_q <= cnt_q - RoundCntW'(1);
						if (cnt_q == '0) begin
							state_q <= FIN;
						end
					end
				end
				FIN: begin
					if (out_free) begin
						result_first_word  <= res[WordW-1:0];
						result_second_word <= res[2*WordW-1:WordW];
						result_last        <= last_q;
						tail_ok            <= res_tail;
						if (dec_q) begin
							chain_text_q <= blk_q;
							chain_core_q <= core_out;
						end else begin
							chain_text_q <= res;
							chain_core_q <= blk_q ^ chain_text_q;
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/ticc_checker.sv
// ----------------------------------------------------------------------------
// ticc_checker
// Port-level checks of the TEA chaining cipher, bound to the top level
// ----------------------------------------------------------------------------
`include "tea_interlace_chain_cipher_macros.svh"

module ticc_checker import ticc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [WordW-1:0]   result_first_word,
	input logic [WordW-1:0]   result_second_word,
	input logic               result_last,
	input logic               tail_ok
);

	// a stalled result beat holds
	`TICC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_first_word) && $stable(result_second_word) && $stable(result_last) && $stable(tail_ok), "stalled result beat changed")

	// a block in flight keeps the input stalled
	`TICC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken while a block is in flight")

	// tail flag only on a last block
	`TICC_ASSERT_NOW(a_tail_last, out_valid && tail_ok, result_last, "tail flag on a block that is not last")

	// tail flag only when the seven trailing bytes are zero
	`TICC_ASSERT_NOW(a_tail_zero, out_valid && tail_ok, (result_second_word == '0) && (result_first_word[WordW-1:8] == '0), "tail flag with nonzero trailing bytes")

endmodule

bind tea_interlace_chain_cipher ticc_checker u_ticc_checker (.*);
